>>> src/playfair_cipher_encryptor_assert.svh
// Assertion macros for the playfair cipher encryptor sequencer (pcf_ctrl)
`ifndef PLAYFAIR_CIPHER_ENCRYPTOR_ASSERT_SVH
`define PLAYFAIR_CIPHER_ENCRYPTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PCF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pcf_pkg.sv
// Shared types, constants and square arithmetic for the playfair cipher encryptor
package pcf_pkg;

    localparam int SQUARE_SIDE      = 5;
    localparam int ALPHABET_LETTERS = 26;
    localparam int SQUARE_CELLS     = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LAST_INDEX       = SQUARE_SIDE - 1;

    localparam int LETTER_W = 5;
    localparam int CELL_W   = $clog2(SQUARE_CELLS);
    localparam int IDX_W    = $clog2(SQUARE_SIDE);
    localparam int OPCODE_W = 3;

    localparam logic [LETTER_W-1:0] LETTER_X = LETTER_W'(23);
    localparam logic [LETTER_W-1:0] LETTER_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] LETTER_I = LETTER_W'(8);

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_KEY    = 3'd1,
        OP_FINISH = 3'd2,
        OP_TEXT   = 3'd3,
        OP_END    = 3'd4
    } opcode_t;

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
    } result_t;

    function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    function automatic logic [IDX_W-1:0] cell_row(input logic [CELL_W-1:0] cell_idx);
        logic [IDX_W-1:0] row;
        row = '0;
        for (int r = 1; r < SQUARE_SIDE; r++)
        begin
            if (cell_idx >= CELL_W'(r * SQUARE_SIDE))
            begin
                row = IDX_W'(r);
            end
        end
        return row;
    endfunction

    function automatic logic [IDX_W-1:0] cell_col(input logic [CELL_W-1:0] cell_idx);
        logic [CELL_W-1:0] base;
        base = CELL_W'(cell_row(cell_idx) * SQUARE_SIDE);
        return IDX_W'(cell_idx - base);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(LAST_INDEX)) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    function automatic logic [CELL_W-1:0] cell_at(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
        return CELL_W'(row * SQUARE_SIDE + col);
    endfunction

endpackage

>>> src/pcf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
module pcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/pcf_ctrl.sv
// Key square builder and pair encryption sequencer around the square memories
`include "playfair_cipher_encryptor_assert.svh"

module pcf_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic [pcf_pkg::OPCODE_W-1:0]     item_opcode,
    input  logic [pcf_pkg::LETTER_W-1:0]     item_letter,
    input  logic                             slot_free,
    output pcf_pkg::result_t                 result
);

    import pcf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FILL = 6'b000010,
        ST_RD_B = 6'b000100,
        ST_CALC = 6'b001000,
        ST_SQ_B = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [ALPHABET_LETTERS-1:0] used_reg, used_next;
    logic [CELL_W-1:0]           fill_reg, fill_next;
    logic                        key_ready_reg, key_ready_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [LETTER_W-1:0]         pend_letter_reg, pend_letter_next;
    logic [LETTER_W-1:0]         walk_reg, walk_next;

    logic [LETTER_W-1:0]         q_reg, q_next;
    logic [CELL_W-1:0]           ca_reg;
    logic [CELL_W-1:0]           nb_reg;
    logic [LETTER_W-1:0]         first_reg;

    opcode_t                     op;
    logic                        accept;
    logic                        letter_ok;
    logic                        key_req;
    logic                        place_req;
    logic [LETTER_W-1:0]         place_letter;
    logic                        used_hit;
    logic                        place_ok;
    logic                        pair_req;
    logic [LETTER_W-1:0]         second_raw;
    logic [LETTER_W-1:0]         p_look;

    logic                        lc_rd_en;
    logic [LETTER_W-1:0]         lc_rd_addr;
    logic [CELL_W-1:0]           lc_rd_data;
    logic                        ks_rd_en;
    logic [CELL_W-1:0]           ks_rd_addr;
    logic [LETTER_W-1:0]         ks_rd_data;

    logic [IDX_W-1:0]            ra, ka, rb, kb;
    logic [CELL_W-1:0]           na, nb;

    assign op         = opcode_t'(item_opcode);
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign letter_ok  = (item_letter < LETTER_W'(ALPHABET_LETTERS));

    assign key_req      = accept && (op == OP_KEY) && !key_ready_reg;
    assign place_req    = key_req || (state_reg == ST_FILL);
    assign place_letter = (state_reg == ST_FILL) ? walk_reg : item_letter;
    assign used_hit     = (place_letter < LETTER_W'(ALPHABET_LETTERS)) ?
                          used_reg[place_letter] : 1'b1;
    assign place_ok     = place_req && !used_hit && (place_letter != LETTER_J) &&
                          (fill_reg < CELL_W'(SQUARE_CELLS));

    assign pair_req   = accept && key_ready_reg && pend_valid_reg &&
                        (((op == OP_TEXT) && letter_ok) || (op == OP_END));
    assign second_raw = ((op == OP_TEXT) && (item_letter != pend_letter_reg)) ?
                        item_letter : LETTER_X;
    assign p_look     = fold_j(pend_letter_reg);
    assign q_next     = fold_j(second_raw);

    assign lc_rd_en   = pair_req || (state_reg == ST_RD_B);
    assign lc_rd_addr = (state_reg == ST_RD_B) ? q_reg : p_look;

    assign ra = cell_row(ca_reg);
    assign ka = cell_col(ca_reg);
    assign rb = cell_row(lc_rd_data);
    assign kb = cell_col(lc_rd_data);

    always_comb
    begin
        if (ra == rb)
        begin
            na = cell_at(ra, wrap_next(ka));
            nb = cell_at(rb, wrap_next(kb));
        end
        else if (ka == kb)
        begin
            na = cell_at(wrap_next(ra), ka);
            nb = cell_at(wrap_next(rb), kb);
        end
        else
        begin
            na = cell_at(ra, kb);
            nb = cell_at(rb, ka);
        end
    end

    assign ks_rd_en   = (state_reg == ST_CALC) || (state_reg == ST_SQ_B);
    assign ks_rd_addr = (state_reg == ST_SQ_B) ? nb_reg : na;

    pcf_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (SQUARE_CELLS)
    ) u_key_square (
        .clk     (clk),
        .wr_en   (place_ok),
        .wr_addr (fill_reg),
        .wr_data (place_letter),
        .rd_en   (ks_rd_en),
        .rd_addr (ks_rd_addr),
        .rd_data (ks_rd_data)
    );

    pcf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (ALPHABET_LETTERS)
    ) u_letter_cell (
        .clk     (clk),
        .wr_en   (place_ok),
        .wr_addr (place_letter),
        .wr_data (fill_reg),
        .rd_en   (lc_rd_en),
        .rd_addr (lc_rd_addr),
        .rd_data (lc_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        fill_next        = fill_reg;
        key_ready_next   = key_ready_reg;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        walk_next        = walk_reg;

        if (place_ok)
        begin
            used_next[place_letter] = 1'b1;
            fill_next               = fill_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            used_next        = '0;
                            fill_next        = '0;
                            key_ready_next   = 1'b0;
                            pend_valid_next  = 1'b0;
                            pend_letter_next = '0;
                        end
                        OP_FINISH:
                        begin
                            if (!key_ready_reg)
                            begin
                                walk_next  = '0;
                                state_next = ST_FILL;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (key_ready_reg && letter_ok)
                            begin
                                if (!pend_valid_reg)
                                begin
                                    pend_valid_next  = 1'b1;
                                    pend_letter_next = item_letter;
                                end
                                else
                                begin
                                    state_next = ST_RD_B;
                                    if (item_letter != pend_letter_reg)
                                    begin
                                        pend_valid_next  = 1'b0;
                                        pend_letter_next = '0;
                                    end
                                end
                            end
                        end
                        OP_END:
                        begin
                            if (pair_req)
                            begin
                                pend_valid_next  = 1'b0;
                                pend_letter_next = '0;
                                state_next       = ST_RD_B;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LETTER_W'(ALPHABET_LETTERS - 1))
                begin
                    key_ready_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD_B:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_SQ_B;
            end
            ST_SQ_B:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            used_reg        <= '0;
            fill_reg        <= '0;
            key_ready_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            walk_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            fill_reg        <= fill_next;
            key_ready_reg   <= key_ready_next;
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            walk_reg        <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_req)
        begin
            q_reg <= q_next;
        end
        if (state_reg == ST_RD_B)
        begin
            ca_reg <= lc_rd_data;
        end
        if (state_reg == ST_CALC)
        begin
            nb_reg <= nb;
        end
        if (state_reg == ST_SQ_B)
        begin
            first_reg <= ks_rd_data;
        end
    end

    assign result.valid  = (state_reg == ST_EMIT) && slot_free;
    assign result.first  = first_reg;
    assign result.second = ks_rd_data;

    `PCF_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CELL_W'(SQUARE_CELLS), "square overfilled")
    `PCF_ASSERT_IMP(a_ready_full, key_ready_reg, fill_reg == CELL_W'(SQUARE_CELLS), "ready square not full")
    `PCF_ASSERT_IMP(a_no_place_ready, key_ready_reg, !place_ok, "square written after finish")
    `PCF_ASSERT_NXT(a_emit_hold, (state_reg == ST_EMIT) && !slot_free, state_reg == ST_EMIT, "result dropped")

endmodule

>>> src/playfair_cipher_encryptor.sv
// Playfair 5x5 encryptor top level: stream ports and output register
//
// Slave channel carries one command per transfer: tuser holds the opcode
// (clear key, key letter, finish key, text letter, end of text) and tdata
// holds the letter. Master channel carries one ciphertext pair per transfer.
// Key letters and clear are handled in the idle state. Finish key walks the alphabet
// through the square memories, one letter per cycle.
// A text letter or end of text that closes a pair goes through two
// reads of the letter-position memory, two reads of the key square memory,
// then the pair loads the output register once that is free; the result
// appears on the master side the cycle after. Other text commands stay in idle.
// Items are handled one at a time; s_axis_tready is high whenever the
// sequencer is idle, also while a finished pair waits in the output register.
// When the receiver stalls, the pair holds in the output register and a
// following pair waits in the sequencer until the register frees.
// Reset empties the square, drops any pending letter and the output pair.
module playfair_cipher_encryptor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [4:0] letter
    input  logic [2:0]  s_axis_tuser,  // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [4:0] first_cipher, [9:5] second_cipher
);

    import pcf_pkg::*;

    result_t             result;
    logic                slot_free;
    logic                out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0] out_first_reg;
    logic [LETTER_W-1:0] out_second_reg;

    assign slot_free = !out_valid_reg || m_axis_tready;

    pcf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_axis_tvalid),
        .item_ready  (s_axis_tready),
        .item_opcode (s_axis_tuser),
        .item_letter (s_axis_tdata[LETTER_W-1:0]),
        .slot_free   (slot_free),
        .result      (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_first_reg  <= result.first;
            out_second_reg <= result.second;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_second_reg, out_first_reg};

endmodule

>>> tb/playfair_cipher_encryptor_test.sv
// Self-checking stream testbench for the Playfair 5x5 cipher encryptor
`timescale 1ns / 100ps

module playfair_cipher_encryptor_test;
    import pcf_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int ITEMS_PER_PHASE = 550;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
    } cipher_pair_t;

    typedef struct packed {
        logic [2:0]          op;
        logic [LETTER_W-1:0] ltr;
        logic                typed;
        logic [LETTER_W-1:0] c1;
        logic [LETTER_W-1:0] c2;
    } stim_row_t;

    localparam int N_ROWS = 29;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [2:0]  s_axis_tuser = OP_CLEAR;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    cipher_pair_t cipher_pairs_due[$];
    int bad_count = 0;
    int sent_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;

    logic [LETTER_W-1:0] sq_letter[SQUARE_CELLS];
    int                  pos_of[ALPHABET_LETTERS];
    bit                  placed[ALPHABET_LETTERS];
    int                  filled;
    bit                  square_done;
    bit                  held_valid;
    logic [LETTER_W-1:0] held_letter;

    stim_row_t stim_table[N_ROWS] = '{
        '{OP_TEXT,     5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_KEY,      5'd31, 1'b0, 5'd0,  5'd0},
        '{OP_KEY,      5'd9,  1'b0, 5'd0,  5'd0},
        '{OP_FINISH,   5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd1,  1'b1, 5'd1,  5'd2},
        '{OP_TEXT,     5'd4,  1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd0,  1'b1, 5'd0,  5'd1},
        '{OP_TEXT,     5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd21, 1'b1, 5'd5,  5'd0},
        '{OP_TEXT,     5'd25, 1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd0,  1'b1, 5'd21, 5'd4},
        '{OP_TEXT,     5'd23, 1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd23, 1'b1, 5'd24, 5'd24},
        '{OP_END,      5'd0,  1'b1, 5'd24, 5'd24},
        '{OP_TEXT,     5'd8,  1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd9,  1'b1, 5'd10, 5'd10},
        '{OP_END,      5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd31, 1'b0, 5'd0,  5'd0},
        '{OP_SPARE_HI, 5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_KEY,      5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_FINISH,   5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd5,  1'b0, 5'd0,  5'd0},
        '{OP_CLEAR,    5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_END,      5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_KEY,      5'd25, 1'b0, 5'd0,  5'd0},
        '{OP_KEY,      5'd25, 1'b0, 5'd0,  5'd0},
        '{OP_FINISH,   5'd0,  1'b0, 5'd0,  5'd0},
        '{OP_TEXT,     5'd25, 1'b0, 5'd0,  5'd0}
    };

    playfair_cipher_encryptor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void place_key_letter(input int l);
        if (l >= ALPHABET_LETTERS || l == int'(LETTER_J) || placed[l] || filled >= SQUARE_CELLS)
        begin
            return;
        end
        sq_letter[filled] = LETTER_W'(l);
        pos_of[l]         = filled;
        placed[l]         = 1'b1;
        filled++;
    endfunction

    function automatic cipher_pair_t encode_pair(input logic [LETTER_W-1:0] p,
                                                 input logic [LETTER_W-1:0] q);
        int ca, cb, ra, ka, rb, kb, na, nb;
        cipher_pair_t r;
        if (p == LETTER_J)
        begin
            p = LETTER_I;
        end
        if (q == LETTER_J)
        begin
            q = LETTER_I;
        end
        ca = pos_of[p];
        cb = pos_of[q];
        ra = ca / SQUARE_SIDE;
        ka = ca % SQUARE_SIDE;
        rb = cb / SQUARE_SIDE;
        kb = cb % SQUARE_SIDE;
        if (ra == rb)
        begin
            na = ra * SQUARE_SIDE + (ka + 1) % SQUARE_SIDE;
            nb = rb * SQUARE_SIDE + (kb + 1) % SQUARE_SIDE;
        end
        else if (ka == kb)
        begin
            na = ((ra + 1) % SQUARE_SIDE) * SQUARE_SIDE + ka;
            nb = ((rb + 1) % SQUARE_SIDE) * SQUARE_SIDE + kb;
        end
        else
        begin
            na = ra * SQUARE_SIDE + kb;
            nb = rb * SQUARE_SIDE + ka;
        end
        r.first  = sq_letter[na];
        r.second = sq_letter[nb];
        return r;
    endfunction

    function automatic void playfair_predict(input logic [2:0] op, input logic [LETTER_W-1:0] ltr,
                                             output bit made, output cipher_pair_t pair);
        made = 1'b0;
        pair = '0;
        case (op)
            OP_CLEAR:
            begin
                for (int i = 0; i < ALPHABET_LETTERS; i++)
                begin
                    placed[i] = 1'b0;
                end
                filled      = 0;
                square_done = 1'b0;
                held_valid  = 1'b0;
                held_letter = '0;
            end
            OP_KEY:
            begin
                if (!square_done)
                begin
                    place_key_letter(int'(ltr));
                end
            end
            OP_FINISH:
            begin
                if (!square_done)
                begin
                    for (int i = 0; i < ALPHABET_LETTERS; i++)
                    begin
                        place_key_letter(i);
                    end
                    square_done = 1'b1;
                end
            end
            OP_TEXT:
            begin
                if (square_done && ltr < ALPHABET_LETTERS)
                begin
                    if (!held_valid)
                    begin
                        held_letter = ltr;
                        held_valid  = 1'b1;
                    end
                    else if (ltr == held_letter)
                    begin
                        pair = encode_pair(held_letter, LETTER_X);
                        made = 1'b1;
                    end
                    else
                    begin
                        pair        = encode_pair(held_letter, ltr);
                        made        = 1'b1;
                        held_valid  = 1'b0;
                        held_letter = '0;
                    end
                end
            end
            OP_END:
            begin
                if (square_done && held_valid)
                begin
                    pair        = encode_pair(held_letter, LETTER_X);
                    made        = 1'b1;
                    held_valid  = 1'b0;
                    held_letter = '0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [LETTER_W-1:0] ltr,
                            input bit typed, input cipher_pair_t typed_pair);
        bit made;
        cipher_pair_t pair;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, ltr};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        playfair_predict(op, ltr, made, pair);
        if (typed)
        begin
            cipher_pairs_due.push_back(typed_pair);
        end
        else if (made)
        begin
            cipher_pairs_due.push_back(pair);
        end
        if (op < OP_SPARE_LO)
        begin
            sent_count++;
        end
    endtask

    task automatic run_session();
        int nkey, ntext, pick;
        logic [LETTER_W-1:0] last_txt;
        last_txt = '0;
        send_cmd(OP_CLEAR, LETTER_W'($urandom_range(31)), 1'b0, '0);
        if ($urandom_range(7) == 0)
        begin
            send_cmd(OP_TEXT, LETTER_W'($urandom_range(31)), 1'b0, '0);
            send_cmd(OP_END, LETTER_W'($urandom_range(31)), 1'b0, '0);
        end
        nkey = $urandom_range(12);
        for (int i = 0; i < nkey; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_cmd(OP_KEY, LETTER_W'($urandom_range(31, ALPHABET_LETTERS)), 1'b0, '0);
            end
            else
            begin
                send_cmd(OP_KEY, LETTER_W'($urandom_range(ALPHABET_LETTERS - 1)), 1'b0, '0);
            end
        end
        send_cmd(OP_FINISH, LETTER_W'($urandom_range(31)), 1'b0, '0);
        ntext = $urandom_range(60, 4);
        for (int i = 0; i < ntext; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                last_txt = LETTER_W'($urandom_range(ALPHABET_LETTERS - 1));
                send_cmd(OP_TEXT, last_txt, 1'b0, '0);
            end
            else if (pick < 80)
            begin
                send_cmd(OP_TEXT, last_txt, 1'b0, '0);
            end
            else if (pick < 88)
            begin
                send_cmd(OP_END, LETTER_W'($urandom_range(31)), 1'b0, '0);
            end
            else if (pick < 92)
            begin
                send_cmd(OP_TEXT, LETTER_W'($urandom_range(31, ALPHABET_LETTERS)), 1'b0, '0);
            end
            else if (pick < 95)
            begin
                send_cmd(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)),
                         LETTER_W'($urandom_range(31)), 1'b0, '0);
            end
            else if (pick < 98)
            begin
                send_cmd(OP_KEY, LETTER_W'($urandom_range(31)), 1'b0, '0);
            end
            else
            begin
                send_cmd(OP_FINISH, LETTER_W'($urandom_range(31)), 1'b0, '0);
            end
        end
        if ($urandom_range(1) == 0)
        begin
            send_cmd(OP_END, LETTER_W'($urandom_range(31)), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        cipher_pair_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_pairs_due.size() == 0)
                begin
                    $error("unexpected pair: first_cipher %0d, second_cipher %0d",
                           m_axis_tdata[4:0], m_axis_tdata[9:5]);
                    bad_count++;
                end
                else
                begin
                    want = cipher_pairs_due.pop_front();
                    if (m_axis_tdata[4:0] !== want.first)
                    begin
                        $error("first_cipher: expected %0d, actual %0d",
                               want.first, m_axis_tdata[4:0]);
                        bad_count++;
                    end
                    if (m_axis_tdata[9:5] !== want.second)
                    begin
                        $error("second_cipher: expected %0d, actual %0d",
                               want.second, m_axis_tdata[9:5]);
                        bad_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        for (int i = 0; i < SQUARE_CELLS; i++)
        begin
            sq_letter[i] = '0;
        end
        for (int i = 0; i < ALPHABET_LETTERS; i++)
        begin
            pos_of[i] = 0;
            placed[i] = 1'b0;
        end
        filled      = 0;
        square_done = 1'b0;
        held_valid  = 1'b0;
        held_letter = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 25;
        sink_idle_pct = 88;
        for (int r = 0; r < N_ROWS; r++)
        begin
            send_cmd(stim_table[r].op, stim_table[r].ltr, stim_table[r].typed,
                     {stim_table[r].c1, stim_table[r].c2});
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct  = 25;
                    sink_idle_pct = 88;
                end
                1:
                begin
                    src_idle_pct  = 88;
                    sink_idle_pct = 25;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            // hold the sender until every pair is out
            s_axis_tvalid <= 1'b0;
            while (cipher_pairs_due.size() != 0)
            begin
                @(posedge clk);
            end
            sent_count = 0;
            while (sent_count < ITEMS_PER_PHASE)
            begin
                run_session();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (cipher_pairs_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bad_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/pcf_pkg.sv
src/pcf_ram.sv
src/pcf_ctrl.sv
src/playfair_cipher_encryptor.sv
tb/playfair_cipher_encryptor_test.sv
